// ===== design/isots_pkg.sv =====
// Shared types, constants and tables for the timestamp-to-epoch converter.
// No dependencies; compiled first.
package isots_pkg;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // Character positions in YYYY-MM-DDTHH:MM:SS(Z|+HH:MM)
  localparam logic [4:0] POS_YEAR_END = 5'd3;
  localparam logic [4:0] POS_SEP_YM   = 5'd4;
  localparam logic [4:0] POS_MON_END  = 5'd6;
  localparam logic [4:0] POS_SEP_MD   = 5'd7;
  localparam logic [4:0] POS_DAY_END  = 5'd9;
  localparam logic [4:0] POS_SEP_DT   = 5'd10;
  localparam logic [4:0] POS_HOUR_END = 5'd12;
  localparam logic [4:0] POS_SEP_HM   = 5'd13;
  localparam logic [4:0] POS_MIN_END  = 5'd15;
  localparam logic [4:0] POS_SEP_MS   = 5'd16;
  localparam logic [4:0] POS_SEC_END  = 5'd18;
  localparam logic [4:0] POS_ZONE     = 5'd19;
  localparam logic [4:0] POS_OFSH_END = 5'd21;
  localparam logic [4:0] POS_SEP_OFS  = 5'd22;
  localparam logic [4:0] POS_LAST_UTC = 5'd19;
  localparam logic [4:0] POS_LAST_OFS = 5'd24;
  localparam logic [4:0] POS_OVERFLOW = 5'd25;
  localparam logic [4:0] POS_SAT      = 5'd31;

  // Range limits and time constants
  localparam logic [13:0] EPOCH_YEAR  = 14'd1970;
  localparam logic [13:0] YEAR_MIN    = 14'd2020;
  localparam logic [13:0] YEAR_MAX    = 14'd2099;
  localparam logic [6:0]  MONTH_FEB   = 7'd2;
  localparam logic [6:0]  MONTH_MAX   = 7'd12;
  localparam logic [6:0]  HOUR_MAX    = 7'd23;
  localparam logic [6:0]  MIN_SEC_MAX = 7'd59;
  localparam logic [6:0]  OFS_HOUR_MAX = 7'd14;
  localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  ofs_hours;
    logic [6:0]  ofs_minutes;
    logic        ofs_negative;
    logic        format_error;
  } fields_t;

  // Completed string handed from the parser to the converter
  typedef struct packed {
    fields_t fields;
    logic    len_ok;
  } snap_t;

  function automatic logic [6:0] acc_dec7(logic [6:0] v, logic [3:0] d);
    return 7'({v, 3'b000} + {v, 1'b0} + 10'(d));
  endfunction

  function automatic logic [13:0] acc_dec14(logic [13:0] v, logic [3:0] d);
    return 14'({v, 3'b000} + {v, 1'b0} + 17'(d));
  endfunction

  // Days in a month, non-leap year; zero for a code that is not a month
  function automatic logic [4:0] month_days(logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the year before the first of a month, non-leap year
  function automatic logic [8:0] days_before(logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/isots_in_if.sv =====
// Character request channel: one ASCII byte plus end-of-string mark.
// No dependencies.
interface isots_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== design/isots_out_if.sv =====
// Result channel: valid flag and Unix epoch seconds.
// No dependencies.
interface isots_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] epoch_seconds;

  modport source (output valid, output valid_res, output epoch_seconds, input ready);
  modport sink   (input valid, input valid_res, input epoch_seconds, output ready);
endinterface

// ===== design/iso8601_timestamp_to_epoch.sv =====
// Top level: RFC 3339 timestamp string to Unix epoch seconds.
// Depends on isots_pkg, isots_in_if, isots_out_if, isots_parse, isots_conv.
//
//  port      dir   payload                         per request
//  char_i    sink  character[7:0], last_char       one byte of the string
//  result_o  src   valid_res, epoch_seconds[31:0]  one per string (final byte)
//
//  One character is taken every cycle unless a held snapshot is not taken; the parser keeps position and fields.
//  After the final byte is accepted, the result passes the string snapshot register,
//  the check/day-count register and the result register (day*86400).
//  Reset clears the position, the digit fields and all pipeline valids.
//  A stalled result_o holds its request; char_i stalls only once the snapshot,
//  check/day-count and result registers are all full.
module iso8601_timestamp_to_epoch (
  input logic           clk_i,
  input logic           rst_ni,
  isots_in_if.sink      char_i,
  isots_out_if.source   result_o
);
  import isots_pkg::*;

  snap_t snap;
  logic  snap_valid, snap_ready;

  isots_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (char_i.valid),
    .ready_o      (char_i.ready),
    .character_i  (char_i.character),
    .last_char_i  (char_i.last_char),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  isots_conv u_conv (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .snap_valid_i    (snap_valid),
    .snap_ready_o    (snap_ready),
    .snap_i          (snap),
    .res_valid_o     (result_o.valid),
    .res_ready_i     (result_o.ready),
    .valid_res_o     (result_o.valid_res),
    .epoch_seconds_o (result_o.epoch_seconds)
  );

endmodule

// ===== design/isots_parse.sv =====
// Per-character format check and decimal field accumulation.
// Depends on isots_pkg; hands a completed string to isots_conv.
module isots_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        character_i,
  input  logic              last_char_i,
  output logic              snap_valid_o,
  input  logic              snap_ready_i,
  output isots_pkg::snap_t  snap_o
);
  import isots_pkg::*;

  logic [4:0] pos_q, pos_d;
  fields_t    fld_q, fld_d, nxt;
  logic       snap_v_q, snap_v_d;
  snap_t      snap_q;
  logic       acc, is_dig;
  logic [3:0] dig;

  assign ready_o = !snap_v_q || snap_ready_i;
  assign acc     = valid_i && ready_o;
  assign is_dig  = (character_i >= CH_ZERO) && (character_i <= CH_NINE);
  assign dig     = character_i[3:0];

  always_comb begin
    nxt = fld_q;
    if (pos_q >= POS_OVERFLOW) begin
      nxt.format_error = 1'b1;
    end else begin
      case (pos_q) inside
        POS_SEP_YM, POS_SEP_MD: begin
          if (character_i != CH_DASH) nxt.format_error = 1'b1;
        end
        POS_SEP_DT: begin
          if (character_i != CH_T) nxt.format_error = 1'b1;
        end
        POS_SEP_HM, POS_SEP_MS, POS_SEP_OFS: begin
          if (character_i != CH_COLON) nxt.format_error = 1'b1;
        end
        POS_ZONE: begin
          if (character_i == CH_Z) begin
            if (!last_char_i) nxt.format_error = 1'b1;
          end else if (character_i == CH_PLUS || character_i == CH_DASH) begin
            if (last_char_i) nxt.format_error = 1'b1;
            nxt.ofs_negative = (character_i == CH_DASH);
          end else begin
            nxt.format_error = 1'b1;
          end
        end
        default: begin
          if (!is_dig) begin
            nxt.format_error = 1'b1;
          end else if (pos_q <= POS_YEAR_END) begin
            nxt.year = acc_dec14(fld_q.year, dig);
          end else if (pos_q <= POS_MON_END) begin
            nxt.month = acc_dec7(fld_q.month, dig);
          end else if (pos_q <= POS_DAY_END) begin
            nxt.day = acc_dec7(fld_q.day, dig);
          end else if (pos_q <= POS_HOUR_END) begin
            nxt.hour = acc_dec7(fld_q.hour, dig);
          end else if (pos_q <= POS_MIN_END) begin
            nxt.minute = acc_dec7(fld_q.minute, dig);
          end else if (pos_q <= POS_SEC_END) begin
            nxt.second = acc_dec7(fld_q.second, dig);
          end else if (pos_q <= POS_OFSH_END) begin
            nxt.ofs_hours = acc_dec7(fld_q.ofs_hours, dig);
          end else begin
            nxt.ofs_minutes = acc_dec7(fld_q.ofs_minutes, dig);
          end
        end
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    fld_d    = fld_q;
    snap_v_d = snap_v_q;
    if (snap_ready_i) snap_v_d = 1'b0;
    if (acc) begin
      if (last_char_i) begin
        pos_d    = '0;
        fld_d    = '0;
        snap_v_d = 1'b1;
      end else begin
        pos_d = (pos_q == POS_SAT) ? POS_SAT : pos_q + 5'd1;
        fld_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fld_q    <= '0;
      snap_v_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      fld_q    <= fld_d;
      snap_v_q <= snap_v_d;
    end
  end

  // final character: freeze the string for the converter
  always_ff @(posedge clk_i) begin
    if (acc && last_char_i) begin
      snap_q.fields <= nxt;
      snap_q.len_ok <= (pos_q == POS_LAST_UTC) || (pos_q == POS_LAST_OFS);
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_o       = snap_q;

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_char_i |=> pos_q == '0)
    else $error("position not cleared after final character");

  a_snap_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_char_i |=> snap_v_q)
    else $error("completed string not handed on");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !last_char_i && pos_q != POS_SAT |=> pos_q == 5'($past(pos_q) + 5'd1))
    else $error("position did not advance");

endmodule

// ===== design/isots_conv.sv =====
// Range checks and epoch arithmetic: a check/day-count stage and a result register.
// Depends on isots_pkg; fed by isots_parse.
module isots_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              snap_valid_i,
  output logic              snap_ready_o,
  input  isots_pkg::snap_t  snap_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              valid_res_o,
  output logic [31:0]       epoch_seconds_o
);
  import isots_pkg::*;

  fields_t     f;
  logic        leap, year_ok, month_ok, day_ok, time_ok, ofs_ok, ok;
  logic [4:0]  mlen;
  logic [7:0]  yoff;
  logic [7:0]  yoff_p1;
  logic [15:0] days;
  logic [16:0] hms;
  logic [15:0] ofs;
  logic [18:0] tod;

  logic        s1_v_q, s1_ok_q;
  logic [15:0] s1_days_q;
  logic [18:0] s1_tod_q;
  logic        out_v_q, valid_res_q;
  logic [31:0] epoch_q, epoch_d;
  logic        out_ready, s1_ready, s1_adv;

  assign f = snap_i.fields;

  always_comb begin
    leap     = (f.year[1:0] == 2'b00);
    year_ok  = (f.year >= YEAR_MIN) && (f.year <= YEAR_MAX);
    month_ok = (f.month != '0) && (f.month <= MONTH_MAX);
    mlen     = month_days(f.month[3:0]) + 5'((f.month == MONTH_FEB) && leap);
    day_ok   = (f.day != '0) && (f.day <= 7'(mlen));
    time_ok  = (f.hour <= HOUR_MAX) && (f.minute <= MIN_SEC_MAX) &&
               (f.second <= MIN_SEC_MAX);
    ofs_ok   = (f.ofs_hours <= OFS_HOUR_MAX) && (f.ofs_minutes <= MIN_SEC_MAX) &&
               !((f.ofs_hours == OFS_HOUR_MAX) && (f.ofs_minutes != '0));
    ok       = !f.format_error && snap_i.len_ok && year_ok && month_ok &&
               day_ok && time_ok && ofs_ok;

    // only meaningful once the year is in range
    yoff    = 8'(f.year - EPOCH_YEAR);
    yoff_p1 = yoff + 8'd1;
    days    = 16'({8'b0, yoff} * DAYS_PER_YEAR) + 16'(yoff_p1[7:2]) +
              16'(days_before(f.month[3:0])) +
              16'(leap && (f.month > MONTH_FEB)) + 16'(f.day) - 16'd1;

    hms = 17'(17'(f.hour) * SEC_PER_HOUR) + 17'(17'(f.minute) * SEC_PER_MIN) +
          17'(f.second);
    ofs = 16'(17'(f.ofs_hours) * SEC_PER_HOUR) +
          16'(17'(f.ofs_minutes) * SEC_PER_MIN);
    // local time minus a positive offset gives UTC
    tod = f.ofs_negative ? 19'(hms) + 19'(ofs) : 19'(hms) - 19'(ofs);
  end

  assign out_ready    = !out_v_q || res_ready_i;
  assign s1_ready     = !s1_v_q || out_ready;
  assign s1_adv       = s1_v_q && out_ready;
  assign snap_ready_o = s1_ready;

  assign epoch_d = s1_ok_q ?
                   32'({16'b0, s1_days_q} * {15'b0, SEC_PER_DAY}) +
                   {{13{s1_tod_q[18]}}, s1_tod_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= snap_valid_i;
      if (out_ready) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && snap_valid_i) begin
      s1_ok_q   <= ok;
      s1_days_q <= days;
      s1_tod_q  <= tod;
    end
    if (s1_adv) begin
      valid_res_q <= s1_ok_q;
      epoch_q     <= epoch_d;
    end
  end

  assign res_valid_o     = out_v_q;
  assign valid_res_o     = valid_res_q;
  assign epoch_seconds_o = epoch_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !valid_res_q |-> epoch_q == '0)
    else $error("invalid result carries nonzero epoch");

  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_i && snap_ready_o |=> s1_v_q)
    else $error("check stage dropped a request");

  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_v_q)
    else $error("result register dropped a request");

endmodule
